FILE: rtl/pll_analog_register_bank_defines.svh
// Assertion macros for the PLL analog register bank.
// Used by the bank and the top level; expects aclk and aresetn in scope.
`ifndef PLL_ANALOG_REGISTER_BANK_DEFINES_SVH
`define PLL_ANALOG_REGISTER_BANK_DEFINES_SVH
`ifndef SYNTHESIS
`define PARB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define PARB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define PARB_ASSERT(lbl, prop, msg)
`define PARB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/parb_pkg.sv
// Package for the PLL analog register bank: region constants, PLL bit
// positions, decoded access type and the lock recompute function.
package parb_pkg;

    localparam int unsigned NUM_WORDS    = 97;
    localparam int unsigned NUM_GROUPS   = (NUM_WORDS + 3) / 4;
    localparam int unsigned GRP_W        = $clog2(NUM_GROUPS);
    localparam int unsigned REGION_BYTES = NUM_WORDS * 4;

    localparam logic [31:0] BASE_ADDR = 32'h400D_8000;

    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam int unsigned EN_POS    = 13;
    localparam int unsigned PWR_POS   = 12;
    localparam int unsigned LOCK_POS  = 31;
    localparam int unsigned ENET2_POS = 20;
    localparam int unsigned R25M_POS  = 21;

    localparam logic [GRP_W-1:0] GRP_ARM   = GRP_W'(12'h000 >> 4);
    localparam logic [GRP_W-1:0] GRP_USB1  = GRP_W'(12'h010 >> 4);
    localparam logic [GRP_W-1:0] GRP_USB2  = GRP_W'(12'h020 >> 4);
    localparam logic [GRP_W-1:0] GRP_SYS   = GRP_W'(12'h030 >> 4);
    localparam logic [GRP_W-1:0] GRP_AUDIO = GRP_W'(12'h070 >> 4);
    localparam logic [GRP_W-1:0] GRP_VIDEO = GRP_W'(12'h0A0 >> 4);
    localparam logic [GRP_W-1:0] GRP_ENET  = GRP_W'(12'h0E0 >> 4);

    typedef enum logic [1:0] {
        ALIAS_BASE = 2'd0,
        ALIAS_SET  = 2'd1,
        ALIAS_CLR  = 2'd2,
        ALIAS_TOG  = 2'd3
    } alias_t;

    typedef struct packed {
        logic              ok;
        logic              wr;
        logic [GRP_W-1:0]  grp;
        alias_t            op;
        logic [1:0]        lane;
        logic [31:0]       lmask;
        logic [31:0]       mask;
        logic [31:0]       data;
    } acc_t;

    function automatic logic [31:0] with_lock(logic [GRP_W-1:0] grp, logic [31:0] v);
        logic lock;
        logic upd;
        logic [31:0] res;
        lock = 1'b0;
        upd  = 1'b1;
        case (grp) inside
            GRP_ARM, GRP_SYS, GRP_AUDIO, GRP_VIDEO:
                lock = v[EN_POS] && !v[PWR_POS];
            GRP_USB1, GRP_USB2:
                lock = v[EN_POS] && v[PWR_POS];
            GRP_ENET:
                lock = (v[EN_POS] || v[ENET2_POS] || v[R25M_POS]) && !v[PWR_POS];
            default:
                upd = 1'b0;
        endcase
        res = v;
        if (upd) begin
            res[LOCK_POS] = lock;
        end
        return res;
    endfunction

endpackage

FILE: rtl/parb_decode.sv
// Access decoder: range and size checks, alias selection and lane shifting.
// Depends on parb_pkg.
module parb_decode import parb_pkg::*; (
    input  logic        kind,
    input  logic [31:0] bus_address,
    input  logic [2:0]  access_size,
    input  logic [31:0] write_data,
    output acc_t        acc
);

    logic [31:0] off;
    logic [32:0] end_off;
    logic        size_ok;
    logic [31:0] lmask;

    always_comb begin
        off     = bus_address - BASE_ADDR;
        end_off = {1'b0, off} + 33'(access_size);
        size_ok = (access_size == SIZE_BYTE) || (access_size == SIZE_HALF)
               || (access_size == SIZE_WORD);
        case (access_size)
            SIZE_WORD: lmask = 32'hFFFF_FFFF;
            SIZE_HALF: lmask = 32'h0000_FFFF;
            default:   lmask = 32'h0000_00FF;
        endcase

        acc.ok    = (bus_address >= BASE_ADDR) && size_ok
                 && (end_off <= 33'(REGION_BYTES));
        acc.wr    = (kind == KIND_WRITE);
        acc.grp   = off[GRP_W+3:4];
        acc.op    = alias_t'(off[3:2]);
        acc.lane  = off[1:0];
        acc.lmask = lmask;
        acc.mask  = lmask << {off[1:0], 3'b000};
        acc.data  = (write_data & lmask) << {off[1:0], 3'b000};
    end

endmodule

FILE: rtl/parb_bank.sv
// Base register bank with set/clear/toggle aliases and PLL lock update.
// Depends on parb_pkg and the assertion macro header.
`include "pll_analog_register_bank_defines.svh"
module parb_bank import parb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  acc_t        acc,
    output logic [31:0] rd_word
);

    logic [31:0] bank_reg [NUM_GROUPS];
    logic [31:0] word_next;

    assign rd_word = bank_reg[acc.grp];

    always_comb begin
        case (acc.op)
            ALIAS_SET: word_next = rd_word | acc.data;
            ALIAS_CLR: word_next = rd_word & ~acc.data;
            ALIAS_TOG: word_next = rd_word ^ acc.data;
            default:   word_next = (rd_word & ~acc.mask) | acc.data;
        endcase
        word_next = with_lock(acc.grp, word_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_GROUPS; i++) begin
                bank_reg[i] <= '0;
            end
        end else if (wr_en) begin
            bank_reg[acc.grp] <= word_next;
        end
    end

    `PARB_ASSERT(a_arm_lock,
        bank_reg[GRP_ARM][LOCK_POS]
            == (bank_reg[GRP_ARM][EN_POS] && !bank_reg[GRP_ARM][PWR_POS]),
        "ARM lock bit out of step")
    `PARB_ASSERT(a_usb1_lock,
        bank_reg[GRP_USB1][LOCK_POS]
            == (bank_reg[GRP_USB1][EN_POS] && bank_reg[GRP_USB1][PWR_POS]),
        "USB1 lock bit out of step")
    `PARB_ASSERT(a_enet_lock,
        bank_reg[GRP_ENET][LOCK_POS]
            == ((bank_reg[GRP_ENET][EN_POS] || bank_reg[GRP_ENET][ENET2_POS]
                 || bank_reg[GRP_ENET][R25M_POS]) && !bank_reg[GRP_ENET][PWR_POS]),
        "ENET lock bit out of step")

endmodule

FILE: rtl/pll_analog_register_bank.sv
// Top level of the PLL analog register bank: input register, decoder,
// bank and result register. Depends on parb_pkg, parb_decode, parb_bank.
//
// Usage:
//   The slave channel takes one bus access per transaction: s_tuser is the
//   access kind (read or write), s_tdata carries address, size and write data.
//   The master channel returns one transaction per access: m_tdata is the
//   read data shifted to lane zero, m_tuser is the access ok flag.
//   Decode and the bank read/modify run from the input register, and the
//   result register loads when the access advances to the output.
//   Throughput is one access per cycle while the receiver is ready; a write
//   updates the bank in the same cycle its result is registered, so the next
//   access sees it at once.
//   Reset clears all 25 base registers and both valid flags.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_tready drops only when both are occupied.
`include "pll_analog_register_bank_defines.svh"
module pll_analog_register_bank import parb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // bus_address[31:0], access_size[34:32], write_data[66:35], zero
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[31:0]
    output logic        m_tuser    // access_ok
);

    logic        in_valid_reg, in_valid_next;
    logic        kind_reg;
    logic [31:0] addr_reg;
    logic [2:0]  size_reg;
    logic [31:0] wdata_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] rdata_reg, rdata_next;
    logic        ok_reg, ok_next;

    logic        s_accept;
    logic        advance;
    acc_t        acc;
    logic [31:0] rd_word;
    logic [31:0] shifted;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    parb_decode u_decode (
        .kind        (kind_reg),
        .bus_address (addr_reg),
        .access_size (size_reg),
        .write_data  (wdata_reg),
        .acc         (acc)
    );

    parb_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (advance && acc.ok && acc.wr),
        .acc     (acc),
        .rd_word (rd_word)
    );

    always_comb begin
        shifted    = rd_word >> {acc.lane, 3'b000};
        rdata_next = (acc.ok && !acc.wr) ? (shifted & acc.lmask) : '0;
        ok_next    = acc.ok;

        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= s_tuser;
            addr_reg  <= s_tdata[31:0];
            size_reg  <= s_tdata[34:32];
            wdata_reg <= s_tdata[66:35];
        end
        if (advance) begin
            rdata_reg <= rdata_next;
            ok_reg    <= ok_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = ok_reg;

    `PARB_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !out_valid_reg,
        "result valid after reset")
    `PARB_ASSERT(a_advance_fills, advance |=> out_valid_reg,
        "advanced transaction lost")
    `PARB_ASSERT(a_reject_zero, (out_valid_reg && !ok_reg) |-> (rdata_reg == '0),
        "rejected access returned data")

endmodule
